FILE: hw/rtl/sld_pkg.sv
// ============================================================================
// sld_pkg: shared types and constants for the packet deframer
// Register indexes, error codes, the queued request and the config bundle.
// ============================================================================
`default_nettype none

package sld_pkg;

   localparam logic [29:0] ALLOC_LIMIT = 30'h3FFF_FFFF;
   localparam logic [23:0] FULL_PACKET = 24'hFF_FFFF;

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_IDX_MODE    = 2'd0;
   localparam logic [1:0] CSR_IDX_PKT_LIM = 2'd1;
   localparam logic [1:0] CSR_IDX_MAX_LEN = 2'd2;

   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_CLOSED_HEADER = 3'd1;
   localparam logic [2:0] ERR_CLOSED_SEQ    = 3'd2;
   localparam logic [2:0] ERR_TOO_LARGE     = 3'd3;
   localparam logic [2:0] ERR_CLOSED_PAYLD  = 3'd4;
   localparam logic [2:0] ERR_BAD_SEQ       = 3'd5;
   localparam logic [2:0] ERR_PKT_LIMIT     = 3'd6;

   typedef struct packed {
      logic       closed;
      logic [7:0] data;
   } sld_item_type;

   typedef struct packed {
      logic        single_mode;
      logic [23:0] pkt_limit;
      logic [29:0] max_len;
   } sld_cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/sld_front.sv
// ============================================================================
// sld_front: request intake queue
// Accepts requests, tags stream closes and holds up to two for the back end.
// ============================================================================
`default_nettype none

module sld_front import sld_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_rx_byte,
   input  wire logic         req_stream_closed,
   output logic              item_valid,
   output sld_item_type      item,
   input  wire logic         item_pop
);

   sld_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   logic         pop;
   sld_item_type new_item;

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = entry_ff[rd_ptr_ff];

   // a close carries no byte
   always_comb begin
      new_item.closed = req_stream_closed;
      new_item.data   = req_stream_closed ? 8'd0 : req_rx_byte;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sld_back.sv
// ============================================================================
// sld_back: deframing state machine and response register
// Parses header, sequence and payload bytes and issues one response each.
// ============================================================================
`default_nettype none

module sld_back import sld_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sld_cfg_type  cfg,
   input  wire logic         item_valid,
   input  wire sld_item_type item,
   output logic              item_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_payload_byte,
   output logic              rsp_payload_valid,
   output logic              rsp_message_done,
   output logic [2:0]        rsp_error_code,
   output logic [7:0]        rsp_expected_seq,
   output logic [29:0]       rsp_message_length
);

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_SEQ     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  hc_ff, hc_in;
   logic [23:0] pl_ff, pl_in;
   logic [23:0] bl_ff, bl_in;
   logic [29:0] total_ff, total_in;
   logic [7:0]  seq_ff, seq_in;
   logic        cont_ff, cont_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  pbyte_ff;
   logic        pvalid_ff;
   logic        done_ff;
   logic [2:0]  err_ff;
   logic [7:0]  eseq_ff;
   logic [29:0] mlen_ff;

   logic        take;
   logic [1:0]  ph;
   logic [1:0]  hc_next;
   logic [30:0] sum;
   logic [2:0]  err;
   logic        done;
   logic        pvalid;
   logic [29:0] report_len;

   assign take     = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign item_pop = take;
   assign ph       = (phase_ff == PH_SEQ || phase_ff == PH_PAYLOAD) ? phase_ff : PH_HEADER;
   assign hc_next  = hc_ff + 2'd1;
   assign sum      = {1'b0, total_ff} + {7'd0, pl_ff};

   always_comb begin
      phase_in = ph;
      hc_in    = hc_ff;
      pl_in    = pl_ff;
      bl_in    = bl_ff;
      total_in = total_ff;
      seq_in   = seq_ff;
      cont_in  = cont_ff;
      err      = ERR_NONE;
      done     = 1'b0;
      pvalid   = 1'b0;
      if (item.closed) begin
         unique case (ph)
            PH_SEQ:     err = ERR_CLOSED_SEQ;
            PH_PAYLOAD: err = ERR_CLOSED_PAYLD;
            default:    err = ERR_CLOSED_HEADER;
         endcase
      end else begin
         unique case (ph)
            PH_SEQ: begin
               if (cfg.single_mode) begin
                  total_in = 30'd0;
                  cont_in  = 1'b0;
                  if (item.data != 8'd1) begin
                     err = ERR_BAD_SEQ;
                  end else begin
                     seq_in = 8'd2;
                  end
               end else if (cont_ff && item.data != seq_ff) begin
                  err = ERR_BAD_SEQ;
               end else begin
                  seq_in = item.data + 8'd1;
                  if (sum > {1'b0, ALLOC_LIMIT} ||
                      (cfg.max_len != 30'd0 && sum > {1'b0, cfg.max_len})) begin
                     err = ERR_TOO_LARGE;
                  end
               end
               if (err == ERR_NONE) begin
                  if (pl_ff == 24'd0) begin
                     done = 1'b1;
                  end else begin
                     bl_in    = pl_ff;
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               pvalid   = 1'b1;
               total_in = total_ff + 30'd1;
               bl_in    = bl_ff - 24'd1;
               if (bl_in == 24'd0) begin
                  if (!cfg.single_mode && pl_ff == FULL_PACKET) begin
                     cont_in  = 1'b1;
                     phase_in = PH_HEADER;
                     hc_in    = 2'd0;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
            default: begin
               case (hc_ff)
                  2'd0:    pl_in = {16'd0, item.data};
                  2'd1:    pl_in = pl_ff | {8'd0, item.data, 8'd0};
                  2'd2:    pl_in = pl_ff | {item.data, 16'd0};
                  default: pl_in = pl_ff;
               endcase
               hc_in = hc_next;
               if (hc_next == 2'd3) begin
                  hc_in = 2'd0;
                  if (cfg.single_mode && pl_in > cfg.pkt_limit) begin
                     err = ERR_PKT_LIMIT;
                  end else begin
                     phase_in = PH_SEQ;
                  end
               end
            end
         endcase
      end
      report_len = total_in;
      if (err != ERR_NONE || done) begin
         phase_in = PH_HEADER;
         hc_in    = 2'd0;
         total_in = 30'd0;
         cont_in  = 1'b0;
      end
      if (err != ERR_NONE) begin
         report_len = 30'd0;
      end
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hc_ff        <= 2'd0;
         pl_ff        <= 24'd0;
         bl_ff        <= 24'd0;
         total_ff     <= 30'd0;
         seq_ff       <= 8'd0;
         cont_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            hc_ff    <= hc_in;
            pl_ff    <= pl_in;
            bl_ff    <= bl_in;
            total_ff <= total_in;
            seq_ff   <= seq_in;
            cont_ff  <= cont_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pbyte_ff  <= pvalid ? item.data : 8'd0;
         pvalid_ff <= pvalid;
         done_ff   <= done;
         err_ff    <= err;
         eseq_ff   <= seq_in;
         mlen_ff   <= report_len;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = pbyte_ff;
   assign rsp_payload_valid  = pvalid_ff;
   assign rsp_message_done   = done_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_expected_seq   = eseq_ff;
   assign rsp_message_length = mlen_ff;

   a_err_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && err_ff != ERR_NONE |-> mlen_ff == 30'd0)
      else $error("error response with nonzero message length");

   a_payload_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pvalid_ff |-> err_ff == ERR_NONE)
      else $error("payload byte flagged with an error");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      take && (err != ERR_NONE || done) |=>
         phase_ff == PH_HEADER && total_ff == 30'd0 && !cont_ff && hc_ff == 2'd0)
      else $error("parser did not restart after error or message end");

endmodule

`default_nettype wire

FILE: hw/rtl/seq_length_packet_deframer.sv
// ============================================================================
// seq_length_packet_deframer: length-prefixed packet deframer with sequence id
// Splits a received byte stream into messages and reports framing errors.
// ============================================================================
// Each request carries one received byte or a stream close; each request
// yields exactly one response with the payload byte (if any), message end,
// error code, next expected sequence number and the message length so far.
// Packets are a 3-byte little-endian length, a sequence byte and the payload.
// A response passes two registers after its request is accepted: first the
// two-entry intake queue, then the parser, whose result is registered.
// Throughput is one request per cycle while rsp_stall is low.
// When rsp_stall is high the response register holds and the queue absorbs
// up to two more requests before req_stall rises.
// Registers sit on the APB port: single packet mode at 0x0, packet length
// limit at 0x4, max message length at 0x8; write them only while idle.
// Reset empties the queue, returns the parser to the header phase, clears
// the sequence number and loads the register reset values.
// ============================================================================
`default_nettype none

module seq_length_packet_deframer import sld_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  req_stream_closed,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_payload_byte,
   output logic                       rsp_payload_valid,
   output logic                       rsp_message_done,
   output logic [2:0]                 rsp_error_code,
   output logic [7:0]                 rsp_expected_seq,
   output logic [29:0]                rsp_message_length,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   sld_cfg_type  cfg_ff;
   sld_item_type item;
   logic         item_valid;
   logic         item_pop;
   logic         csr_wr;
   logic [1:0]   csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.single_mode <= 1'b0;
         cfg_ff.pkt_limit   <= FULL_PACKET;
         cfg_ff.max_len     <= 30'd0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_IDX_MODE:    cfg_ff.single_mode <= pwdata[0];
            CSR_IDX_PKT_LIM: cfg_ff.pkt_limit   <= pwdata[23:0];
            CSR_IDX_MAX_LEN: cfg_ff.max_len     <= pwdata[29:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_MODE:    prdata = {31'd0, cfg_ff.single_mode};
         CSR_IDX_PKT_LIM: prdata = {8'd0, cfg_ff.pkt_limit};
         CSR_IDX_MAX_LEN: prdata = {2'd0, cfg_ff.max_len};
         default:         prdata = 32'd0;
      endcase
   end

   sld_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_stream_closed (req_stream_closed),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop)
   );

   sld_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_message_done   (rsp_message_done),
      .rsp_error_code     (rsp_error_code),
      .rsp_expected_seq   (rsp_expected_seq),
      .rsp_message_length (rsp_message_length)
   );

endmodule

`default_nettype wire
